FILE: src/rsim_pkg.sv
// Package for the range set insert and match block.
// Holds field widths, the operation code, and the controller/datapath command
// and status structs. It depends on nothing else.
package rsim_pkg;

  localparam int unsigned ID_W      = 63;
  localparam int unsigned HIT_W     = 32;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned S_TDATA_W = 192;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic hit;
    logic miss;
    logic query;
    logic full;
    logic out_busy;
  } sts_t;

endpackage

FILE: src/rsim_ctrl.sv
// Controller state machine for the range set insert and match block.
// Sequences load, table scan, write back and result hand-off.
// Depends on rsim_pkg.
module rsim_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsim_pkg::sts_t sts_i,
  output rsim_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.skip) begin
          state_d = ST_FINISH;
        end else if (sts_i.hit) begin
          state_d = sts_i.query ? ST_FINISH : ST_WRITE;
        end else if (sts_i.miss) begin
          state_d = (sts_i.query || sts_i.full) ? ST_FINISH : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/rsim_dp.sv
// Datapath for the range set insert and match block: range table memory,
// item registers, scan comparator, counters and the result register.
// Depends on rsim_pkg and is driven by rsim_ctrl.
module rsim_dp #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rsim_pkg::cmd_t                  cmd_i,
  output rsim_pkg::sts_t                  sts_o,
  input  logic                            op_i,
  input  logic [rsim_pkg::ID_W-1:0]       range_low_i,
  input  logic [rsim_pkg::ID_W-1:0]       range_high_i,
  input  logic [rsim_pkg::ID_W-1:0]       query_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            is_member_o,
  output logic [rsim_pkg::HIT_W-1:0]      hit_total_o,
  output logic                            table_overflow_o,
  output logic [rsim_pkg::CNT_OUT_W-1:0]  entries_used_o
);

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned WW = (CW > rsim_pkg::CNT_OUT_W) ? CW : rsim_pkg::CNT_OUT_W;
  localparam int unsigned XW = rsim_pkg::ID_W + 1;
  localparam int unsigned HIT_W = rsim_pkg::HIT_W;

  typedef struct packed {
    logic [rsim_pkg::ID_W-1:0] first;
    logic [rsim_pkg::ID_W-1:0] last;
  } entry_t;

  entry_t mem_q [MAX_RANGES];
  entry_t rdata_q;

  rsim_pkg::op_e              op_q;
  logic [rsim_pkg::ID_W-1:0]  lo_q, hi_q, id_q;
  logic [CW-1:0]              k_q, used_q;
  logic                       chk_q;
  logic [IW-1:0]              wr_addr_q;
  logic [rsim_pkg::ID_W-1:0]  wr_first_q, wr_last_q;
  logic                       app_q, member_q, ovf_q;
  logic [rsim_pkg::HIT_W-1:0] hits_q, hits_d;
  logic                       out_valid_q;
  logic                       out_member_q, out_ovf_q;
  logic [rsim_pkg::HIT_W-1:0] out_hits_q;
  logic [rsim_pkg::CNT_OUT_W-1:0] out_used_q;

  logic          match, hit, miss, skip, full, issue;
  logic [WW-1:0] used_ext;

  always_comb begin
    if (op_q == rsim_pkg::OP_QUERY) begin
      match = (id_q >= rdata_q.first) && (id_q <= rdata_q.last);
    end else begin
      match = (({1'b0, hi_q} + XW'(1)) >= {1'b0, rdata_q.first}) &&
              ({1'b0, lo_q} <= ({1'b0, rdata_q.last} + XW'(1)));
    end
  end

  assign skip  = (op_q == rsim_pkg::OP_INSERT) && (lo_q > hi_q);
  assign full  = (used_q == CW'(MAX_RANGES));
  assign hit   = cmd_i.scan && !skip && chk_q && match;
  assign miss  = cmd_i.scan && !skip && !hit && (k_q == used_q);
  assign issue = cmd_i.scan && !hit && (k_q < used_q);

  assign sts_o.skip     = skip;
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign sts_o.query    = (op_q == rsim_pkg::OP_QUERY);
  assign sts_o.full     = full;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign hits_d   = (member_q && (hits_q != '1)) ? hits_q + HIT_W'(1) : hits_q;
  assign used_ext = WW'(used_q);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem_q[k_q[IW-1:0]];
    end
    if (cmd_i.write) begin
      mem_q[wr_addr_q] <= '{first: wr_first_q, last: wr_last_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= rsim_pkg::op_e'(op_i);
      lo_q <= range_low_i;
      hi_q <= range_high_i;
      id_q <= query_id_i;
    end
    if (hit) begin
      wr_addr_q  <= IW'(k_q - CW'(1));
      wr_first_q <= (lo_q < rdata_q.first) ? lo_q : rdata_q.first;
      wr_last_q  <= (hi_q > rdata_q.last) ? hi_q : rdata_q.last;
    end else if (miss) begin
      wr_addr_q  <= used_q[IW-1:0];
      wr_first_q <= lo_q;
      wr_last_q  <= hi_q;
    end
    if (cmd_i.finish) begin
      out_member_q <= member_q;
      out_ovf_q    <= ovf_q;
      out_hits_q   <= hits_d;
      out_used_q   <= used_ext[rsim_pkg::CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      chk_q       <= 1'b0;
      used_q      <= '0;
      app_q       <= 1'b0;
      member_q    <= 1'b0;
      ovf_q       <= 1'b0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        k_q      <= '0;
        chk_q    <= 1'b0;
        app_q    <= 1'b0;
        member_q <= 1'b0;
        ovf_q    <= 1'b0;
      end else begin
        chk_q <= issue;
        if (issue) begin
          k_q <= k_q + CW'(1);
        end
      end
      if (hit) begin
        member_q <= (op_q == rsim_pkg::OP_QUERY);
        app_q    <= 1'b0;
      end else if (miss) begin
        ovf_q <= (op_q == rsim_pkg::OP_INSERT) && full;
        app_q <= 1'b1;
      end
      if (cmd_i.write && app_q) begin
        used_q <= used_q + CW'(1);
      end
      if (cmd_i.finish) begin
        hits_q      <= hits_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_member_o      = out_member_q;
  assign hit_total_o      = out_hits_q;
  assign table_overflow_o = out_ovf_q;
  assign entries_used_o   = out_used_q;

endmodule

FILE: src/range_set_insert_and_match.sv
// Top level of the range set insert and match block.
// Joins the controller rsim_ctrl and the datapath rsim_dp; uses rsim_pkg.
// Channel  Dir  tdata fields (low bit up)                          tuser
// s_axis   in   range_low[62:0] range_high[125:63] query_id[188:126] operation
// m_axis   out  is_member[0] hit_total[32:1] table_overflow[33]   none
//               entries_used[42:34]
// The table memory is read one entry per cycle, up to the N entries in use;
// an inverted insert (range_low above range_high) skips the scan.
// Reset clears the counters and the entry count; the table needs no clearing.
// A new item is taken while a finished result waits in the output register;
// the next result waits until that one has been taken.
module range_set_insert_and_match #(
  parameter int unsigned MAX_RANGES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // range_low, range_high, query_id, zero pad.
  input  logic [rsim_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // operation.
  input  logic [0:0]                          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // is_member, hit_total, table_overflow, entries_used, zero pad.
  output logic [rsim_pkg::M_TDATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned IDW = rsim_pkg::ID_W;

  rsim_pkg::cmd_t cmd;
  rsim_pkg::sts_t sts;

  logic                               is_member;
  logic [rsim_pkg::HIT_W-1:0]         hit_total;
  logic                               table_overflow;
  logic [rsim_pkg::CNT_OUT_W-1:0]     entries_used;

  rsim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsim_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (s_axis_tuser_i[0]),
    .range_low_i      (s_axis_tdata_i[IDW-1:0]),
    .range_high_i     (s_axis_tdata_i[2*IDW-1:IDW]),
    .query_id_i       (s_axis_tdata_i[3*IDW-1:2*IDW]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .is_member_o      (is_member),
    .hit_total_o      (hit_total),
    .table_overflow_o (table_overflow),
    .entries_used_o   (entries_used)
  );

  assign m_axis_tdata_o = {5'b0, entries_used, table_overflow, hit_total, is_member};

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("A second item was taken while one was in work.");

  a_result_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("A finished item did not raise the result valid.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("A pending result was overwritten.");

  a_single_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.hit || sts.miss) |-> cmd.scan && !(sts.hit && sts.miss))
    else $error("The scan reported an outcome outside the scan state.");

endmodule
